[sv/apap_pkg.sv]
// apap_pkg: shared constants, controller states and command/status types
package apap_pkg;

  localparam int DEPTH   = 64;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int SPLIT_W = 7;

  typedef enum logic [3:0] {
    S_LOAD,
    S_L_RD,
    S_L_CHK,
    S_R_DEC,
    S_R_CHK,
    S_SW_L,
    S_SW_R,
    S_E_RD,
    S_E_WR
  } state_t;

  typedef enum logic [1:0] {
    RD_LEFT,
    RD_RIGHT_DEC,
    RD_INDEX
  } rd_sel_t;

  typedef struct packed {
    logic    accept_en;
    logic    cap_left;
    logic    cap_right;
    logic    left_inc;
    logic    right_dec;
    logic    wr_swap_left;
    logic    wr_swap_right;
    logic    emit_load;
    logic    run_done;
    rd_sel_t rd_sel;
  } cmd_t;

  typedef struct packed {
    logic last_xfer;
    logic left_less;
    logic right_greater;
    logic left_next_meets;
    logic right_prev_meets;
    logic index_last;
    logic out_free;
  } sts_t;

endpackage

[sv/apap_in_if.sv]
// apap_in_if: input channel carrying one run element per transfer
interface apap_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [apap_pkg::DATA_W-1:0]  value;
  logic                                is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink   (input valid, input value, input is_last, output ready);
endinterface

[sv/apap_out_if.sv]
// apap_out_if: result channel carrying one partitioned element per transfer
interface apap_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [apap_pkg::DATA_W-1:0]  element;
  logic [apap_pkg::SPLIT_W-1:0]        split_index;
  logic                                end_of_run;
  logic                                overflow;

  modport source (output valid, output element, output split_index,
                  output end_of_run, output overflow, input ready);
  modport sink   (input valid, input element, input split_index,
                  input end_of_run, input overflow, output ready);
endinterface

[sv/apap_ram.sv]
// apap_ram: generic single-write, single-read RAM with registered read data
module apap_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/apap_ctrl.sv]
// apap_ctrl: sequencer for load, partition and emit phases
module apap_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  apap_pkg::sts_t  sts,
  output apap_pkg::cmd_t  cmd
);

  apap_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= apap_pkg::S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      apap_pkg::S_LOAD: begin
        if (sts.last_xfer) state_nxt = apap_pkg::S_L_RD;
      end
      apap_pkg::S_L_RD: state_nxt = apap_pkg::S_L_CHK;
      apap_pkg::S_L_CHK: begin
        if (!sts.left_less)          state_nxt = apap_pkg::S_R_DEC;
        else if (sts.left_next_meets) state_nxt = apap_pkg::S_E_RD;
        else                          state_nxt = apap_pkg::S_L_RD;
      end
      apap_pkg::S_R_DEC: begin
        if (sts.right_prev_meets) state_nxt = apap_pkg::S_E_RD;
        else                      state_nxt = apap_pkg::S_R_CHK;
      end
      apap_pkg::S_R_CHK: begin
        if (sts.right_greater) state_nxt = apap_pkg::S_R_DEC;
        else                   state_nxt = apap_pkg::S_SW_L;
      end
      apap_pkg::S_SW_L: state_nxt = apap_pkg::S_SW_R;
      apap_pkg::S_SW_R: begin
        if (sts.left_next_meets) state_nxt = apap_pkg::S_E_RD;
        else                     state_nxt = apap_pkg::S_L_RD;
      end
      apap_pkg::S_E_RD: state_nxt = apap_pkg::S_E_WR;
      apap_pkg::S_E_WR: begin
        if (sts.out_free) begin
          if (sts.index_last) state_nxt = apap_pkg::S_LOAD;
          else                state_nxt = apap_pkg::S_E_RD;
        end
      end
      default: state_nxt = apap_pkg::S_LOAD;
    endcase
  end

  // commands
  always_comb begin
    cmd        = '0;
    cmd.rd_sel = apap_pkg::RD_LEFT;
    case (state_r)
      apap_pkg::S_LOAD: cmd.accept_en = 1'b1;
      apap_pkg::S_L_RD: cmd.rd_sel = apap_pkg::RD_LEFT;
      apap_pkg::S_L_CHK: begin
        cmd.cap_left = 1'b1;
        cmd.left_inc = sts.left_less;
      end
      apap_pkg::S_R_DEC: begin
        cmd.rd_sel    = apap_pkg::RD_RIGHT_DEC;
        cmd.right_dec = 1'b1;
      end
      apap_pkg::S_R_CHK: cmd.cap_right = 1'b1;
      apap_pkg::S_SW_L:  cmd.wr_swap_left = 1'b1;
      apap_pkg::S_SW_R: begin
        cmd.wr_swap_right = 1'b1;
        cmd.left_inc      = 1'b1;
      end
      apap_pkg::S_E_RD: cmd.rd_sel = apap_pkg::RD_INDEX;
      apap_pkg::S_E_WR: begin
        cmd.rd_sel    = apap_pkg::RD_INDEX;
        cmd.emit_load = sts.out_free;
        cmd.run_done  = sts.out_free && sts.index_last;
      end
      default: cmd = '0;
    endcase
  end

endmodule

[sv/apap_dp.sv]
// apap_dp: element store, partition pointers, pivot and output register
module apap_dp (
  input  logic             clk,
  input  logic             rst_n,
  apap_in_if.sink          in_ch,
  apap_out_if.source       out_ch,
  input  apap_pkg::cmd_t   cmd,
  output apap_pkg::sts_t   sts
);

  localparam int AW = apap_pkg::ADDR_W;
  localparam int CW = apap_pkg::CNT_W;
  localparam int DW = apap_pkg::DATA_W;

  logic [CW-1:0]        count_r, left_r, right_r;
  logic [AW-1:0]        index_r;
  logic                 ovf_r;
  logic signed [DW-1:0] pivot_r, lval_r, rval_r;

  logic                 out_valid_r;
  logic signed [DW-1:0] out_elem_r;
  logic [CW-1:0]        out_split_r;
  logic                 out_end_r, out_ovf_r;

  logic                 xfer, has_room;
  logic [CW-1:0]        count_new, right_m1, left_p1;
  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [DW-1:0]        wdata, rdata;
  logic signed [DW-1:0] rd_val;

  assign xfer      = cmd.accept_en && in_ch.valid;
  assign has_room  = count_r < CW'(apap_pkg::DEPTH);
  assign count_new = has_room ? count_r + CW'(1) : count_r;
  assign right_m1  = right_r - CW'(1);
  assign left_p1   = left_r + CW'(1);
  assign rd_val    = rdata;

  assign in_ch.ready = cmd.accept_en;

  // write port shared by loading and the two halves of a swap
  always_comb begin
    we    = 1'b0;
    waddr = count_r[AW-1:0];
    wdata = in_ch.value;
    if (xfer && has_room) begin
      we = 1'b1;
    end else if (cmd.wr_swap_left) begin
      we    = 1'b1;
      waddr = left_r[AW-1:0];
      wdata = rval_r;
    end else if (cmd.wr_swap_right) begin
      we    = 1'b1;
      waddr = right_r[AW-1:0];
      wdata = lval_r;
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      apap_pkg::RD_LEFT:      raddr = left_r[AW-1:0];
      apap_pkg::RD_RIGHT_DEC: raddr = right_m1[AW-1:0];
      apap_pkg::RD_INDEX:     raddr = index_r;
      default:                raddr = left_r[AW-1:0];
    endcase
  end

  apap_ram #(.WIDTH(DW), .DEPTH(apap_pkg::DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign sts.last_xfer        = xfer && in_ch.is_last;
  assign sts.left_less        = rd_val < pivot_r;
  assign sts.right_greater    = pivot_r < rd_val;
  assign sts.left_next_meets  = left_p1 == right_r;
  assign sts.right_prev_meets = right_m1 == left_r;
  assign sts.index_last       = (CW'(index_r) + CW'(1)) == count_r;
  assign sts.out_free         = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      left_r  <= '0;
      right_r <= '0;
      index_r <= '0;
    end else begin
      if (xfer) begin
        count_r <= count_new;
        if (!has_room) ovf_r <= 1'b1;
        if (in_ch.is_last) begin
          left_r  <= '0;
          right_r <= count_new;
          index_r <= '0;
        end
      end
      if (cmd.left_inc)  left_r  <= left_p1;
      if (cmd.right_dec) right_r <= right_m1;
      if (cmd.emit_load) index_r <= index_r + AW'(1);
      if (cmd.run_done) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end
    end
  end

  // pivot is the last stored element; its value stays fixed across swaps
  always_ff @(posedge clk) begin
    if (xfer && has_room) pivot_r <= in_ch.value;
    if (cmd.cap_left)     lval_r  <= rd_val;
    if (cmd.cap_right)    rval_r  <= rd_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_elem_r  <= rd_val;
      out_split_r <= left_r;
      out_end_r   <= sts.index_last;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.element     = out_elem_r;
  assign out_ch.split_index = apap_pkg::SPLIT_W'(out_split_r);
  assign out_ch.end_of_run  = out_end_r;
  assign out_ch.overflow    = out_ovf_r;

  a_ptr_order: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= right_r)
    else $error("left pointer passed right pointer");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(apap_pkg::DEPTH))
    else $error("element count beyond store depth");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> count_r == CW'(apap_pkg::DEPTH))
    else $error("overflow flagged with store not full");

  a_no_load_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.accept_en && cmd.emit_load))
    else $error("load and emit overlap");

endmodule

[sv/array_partition_around_pivot.sv]
// array_partition_around_pivot: top level, partitions a stored run around its final element
//
// Usage: in_ch carries signed 32-bit elements, one per transfer; the transfer with
// is_last high closes the run. The last stored element is the pivot. Up to DEPTH
// elements are stored; later ones, the last-marked one included, are dropped and
// every result of that run carries overflow high.
// Loading accepts one element per cycle while in_ch is valid. The partition then runs
// on the single-write, single-read registered-read store: each left or right pointer
// step reads the store then compares, and a swap writes its two halves in turn. Emitting
// reads the store then loads the output register per element; an out_ch stall holds it.
// out_ch gives every stored element in its new order with split_index, the
// position where the two pointers met; end_of_run marks the final one.
// in_ch.ready is low from the last transfer of a run until the last result has
// entered the output register. A stall on out_ch holds the output register and
// the emit sequence; the block takes the next run while the final result waits.
// Reset (rst_n low, synchronous) empties the run and the output register; the
// store needs no clearing.
module array_partition_around_pivot (
  input  logic         clk,
  input  logic         rst_n,
  apap_in_if.sink      in_ch,
  apap_out_if.source   out_ch
);

  apap_pkg::cmd_t cmd;
  apap_pkg::sts_t sts;

  apap_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  apap_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule

[verif/array_partition_around_pivot_tb.sv]
// array_partition_around_pivot_tb: self-checking testbench for the run partition block
`timescale 1ns / 1ps

module array_partition_around_pivot_tb;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 220;

  typedef enum int {
    VAL_FULL,
    VAL_NARROW,
    VAL_EXTREME
  } val_mode_t;

  typedef struct packed {
    logic [apap_pkg::DATA_W-1:0]  element;
    logic [apap_pkg::SPLIT_W-1:0] split_index;
    logic                         end_of_run;
    logic                         overflow;
  } part_result_t;

  logic clk;
  logic rst_n;

  apap_in_if  in_ch ();
  apap_out_if out_ch ();

  array_partition_around_pivot dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state
  logic signed [apap_pkg::DATA_W-1:0] run_elems [apap_pkg::DEPTH];
  int                                 run_len;
  logic                               run_overflow;
  part_result_t                       partitioned_q [$];

  int  err_count;
  int  items_sent;
  int  cycle_count;
  int  rx_hold_cycles;
  bit  tx_idle_on;
  bit  rx_idle_on;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // hoare-style partition on the stored run, pivot is the last stored element
  function automatic int partition_run(int n);
    int lp;
    int rp;
    int pp;
    logic signed [apap_pkg::DATA_W-1:0] t;
    lp = 0;
    rp = n;
    pp = n - 1;
    while (lp != rp) begin
      while (run_elems[lp] < run_elems[pp]) begin
        lp++;
        if (lp == rp) return lp;
      end
      do begin
        rp--;
        if (lp == rp) return lp;
      end while (run_elems[pp] < run_elems[rp]);
      t = run_elems[lp];
      run_elems[lp] = run_elems[rp];
      run_elems[rp] = t;
      if (pp == lp) pp = rp;
      else if (pp == rp) pp = lp;
      lp++;
    end
    return lp;
  endfunction

  task automatic predict_partition(input logic signed [apap_pkg::DATA_W-1:0] v,
                                   input logic last);
    int split;
    part_result_t r;
    if (run_len < apap_pkg::DEPTH) begin
      run_elems[run_len] = v;
      run_len++;
    end else begin
      run_overflow = 1'b1;
    end
    if (last) begin
      split = partition_run(run_len);
      for (int k = 0; k < run_len; k++) begin
        r.element     = run_elems[k];
        r.split_index = split[apap_pkg::SPLIT_W-1:0];
        r.end_of_run  = (k + 1 == run_len);
        r.overflow    = run_overflow;
        partitioned_q.push_back(r);
      end
      run_len      = 0;
      run_overflow = 1'b0;
    end
  endtask

  // called at a rising edge; returns at the edge of the transfer
  task automatic send_elem(input logic signed [apap_pkg::DATA_W-1:0] v,
                           input logic last);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.value   <= v;
    in_ch.is_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    predict_partition(v, last);
    items_sent++;
  endtask

  function automatic logic signed [apap_pkg::DATA_W-1:0] rand_value(val_mode_t mode);
    int v;
    case (mode)
      VAL_NARROW: begin
        v = $urandom_range(0, 8);
        return v - 4;
      end
      VAL_EXTREME: begin
        case ($urandom_range(0, 4))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sh0000_0000;
          3: return -32'sd1;
          default: return $urandom;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_run(input int len, input val_mode_t mode);
    for (int i = 0; i < len; i++)
      send_elem(rand_value(mode), i == len - 1);
  endtask

  // result side: random wait before each transfer, plus an optional long hold
  initial begin : result_sink
    int gap;
    out_ch.ready <= 1'b0;
    forever begin
      if (rx_hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      gap = rx_idle_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  always @(posedge clk) begin : check_results
    part_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (partitioned_q.size() == 0) begin
        $error("unexpected result: element %0d", out_ch.element);
        err_count++;
      end else begin
        want = partitioned_q.pop_front();
        if (out_ch.element !== want.element) begin
          $error("element: expected %0d, got %0d", $signed(want.element), out_ch.element);
          err_count++;
        end
        if (out_ch.split_index !== want.split_index) begin
          $error("split_index: expected %0d, got %0d", want.split_index, out_ch.split_index);
          err_count++;
        end
        if (out_ch.end_of_run !== want.end_of_run) begin
          $error("end_of_run: expected %0b, got %0b", want.end_of_run, out_ch.end_of_run);
          err_count++;
        end
        if (out_ch.overflow !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, out_ch.overflow);
          err_count++;
        end
      end
    end
  end

  task automatic test_single_element();
    send_elem(32'sh8000_0000, 1'b1);
  endtask

  task automatic test_extreme_values();
    send_elem(32'sh7fff_ffff, 1'b0);
    send_elem(32'sh8000_0000, 1'b0);
    send_elem(32'sh0000_0000, 1'b0);
    send_elem(-32'sd1,        1'b0);
    send_elem(32'sd1,         1'b0);
    send_elem(32'sh0000_0000, 1'b1);
  endtask

  task automatic test_equal_values();
    for (int i = 0; i < 4; i++)
      send_elem(32'sd5, i == 3);
  endtask

  task automatic test_sorted_and_reversed();
    for (int i = 1; i <= 4; i++)
      send_elem(i, i == 4);
    for (int i = 4; i >= 1; i--)
      send_elem(i, i == 1);
  endtask

  task automatic test_pivot_extremes();
    send_elem(32'sd3,         1'b0);
    send_elem(-32'sd2,        1'b0);
    send_elem(32'sh7fff_ffff, 1'b1);
    send_elem(32'sd5,         1'b0);
    send_elem(-32'sd7,        1'b0);
    send_elem(32'sh8000_0000, 1'b1);
  endtask

  // full store, one past it, and well past it (last-marked element dropped)
  task automatic test_overflow();
    send_run(apap_pkg::DEPTH, VAL_FULL);
    send_run(apap_pkg::DEPTH + 1, VAL_NARROW);
    send_run(apap_pkg::DEPTH + 8, VAL_FULL);
  endtask

  task automatic test_random_runs();
    int start;
    int len;
    int pick;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 70)      len = $urandom_range(1, 12);
      else if (pick < 90) len = $urandom_range(13, 40);
      else if (pick < 97) len = $urandom_range(41, apap_pkg::DEPTH);
      else                len = $urandom_range(apap_pkg::DEPTH + 1, apap_pkg::DEPTH + 8);
      send_run(len, val_mode_t'($urandom_range(0, 2)));
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // receiver stalls long while runs keep coming, so the input side must block
  task automatic test_backpressure();
    rx_hold_cycles = 400;
    tx_idle_on     = 1'b0;
    send_run(20, VAL_FULL);
    send_run(30, VAL_NARROW);
    send_run(10, VAL_EXTREME);
    tx_idle_on     = 1'b1;
  endtask

  initial begin : main
    err_count      = 0;
    items_sent     = 0;
    cycle_count    = 0;
    rx_hold_cycles = 0;
    run_len        = 0;
    run_overflow   = 1'b0;
    tx_idle_on     = 1'b1;
    rx_idle_on     = 1'b1;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.value   <= '0;
    in_ch.is_last <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_single_element();
    test_extreme_values();
    test_equal_values();
    test_sorted_and_reversed();
    test_pivot_extremes();
    test_overflow();
    test_random_runs();
    test_backpressure();

    in_ch.valid <= 1'b0;
    while (partitioned_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
